// ----- src/opbb_pkg.sv -----
// Shared types and constants of the one-pole bass boost block.
package opbb_pkg;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_ALPHA  = 2'd0;
  localparam logic [1:0] REG_BOOST  = 2'd1;
  localparam logic [1:0] REG_CHCNT  = 2'd2;
  localparam logic [1:0] REG_FORMAT = 2'd3;

  // Register reset values
  localparam logic [15:0] ALPHA_RST  = 16'd63843;
  localparam logic [15:0] BOOST_RST  = 16'd8192;
  localparam logic [3:0]  CHCNT_RST  = 4'd2;
  localparam logic        FORMAT_RST = 1'b0;

  // Sample format codes
  localparam logic FMT_S16 = 1'b0;
  localparam logic FMT_S32 = 1'b1;

  // Accumulator width: products and sums stay below 2^49 in magnitude
  localparam int ACC_W = 50;
  // Channel count / index arithmetic width (holds 32 and 15)
  localparam int CNT_W = 6;

  // Saturation limits of the output
  localparam logic signed [20:0] S16_MAX_Q = 21'sd32767;
  localparam logic signed [20:0] S16_MIN_Q = -21'sd32768;
  localparam logic signed [36:0] S32_MAX_Q = 37'sd2147483647;
  localparam logic signed [36:0] S32_MIN_Q = -37'sd2147483648;
  localparam logic [31:0] S16_MAX_OUT = 32'h0000_7FFF;
  localparam logic [31:0] S16_MIN_OUT = 32'hFFFF_8000;
  localparam logic [31:0] S32_MAX_OUT = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN_OUT = 32'h8000_0000;

  // Configuration register set
  typedef struct packed {
    logic [15:0] alpha_coeff;
    logic [15:0] boost_gain;
    logic [3:0]  channel_count;
    logic        sample_format;
  } cfg_t;

  // Controller to datapath strobes, one per step of an item
  typedef struct packed {
    logic load;     // capture item, pick channel
    logic mul_a;    // prod = alpha * prev
    logic mul_b;    // prod = (1 - alpha) * x, acc = alpha term
    logic sum;      // acc = acc + prod
    logic low;      // round low-pass, write back
    logic mul_c;    // prod = boost * low
    logic add;      // acc = x * 8192 + prod
    logic out_load; // round, saturate, load output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bypass;   // boost gain is zero
  } dp_sts_t;

endpackage

// ----- src/opbb_cfg.sv -----
// APB register file of the one-pole bass boost block.
module opbb_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output opbb_pkg::cfg_t      cfg,
  output logic                clr
);

  opbb_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // channel count write wipes the filter state
  assign clr = wr_en && (reg_idx == opbb_pkg::REG_CHCNT);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha_coeff   <= opbb_pkg::ALPHA_RST;
      cfg_r.boost_gain    <= opbb_pkg::BOOST_RST;
      cfg_r.channel_count <= opbb_pkg::CHCNT_RST;
      cfg_r.sample_format <= opbb_pkg::FORMAT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        opbb_pkg::REG_ALPHA:  cfg_r.alpha_coeff   <= pwdata[15:0];
        opbb_pkg::REG_BOOST:  cfg_r.boost_gain    <= pwdata[15:0];
        opbb_pkg::REG_CHCNT:  cfg_r.channel_count <= pwdata[3:0];
        opbb_pkg::REG_FORMAT: cfg_r.sample_format <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      opbb_pkg::REG_ALPHA:  prdata = {16'd0, cfg_r.alpha_coeff};
      opbb_pkg::REG_BOOST:  prdata = {16'd0, cfg_r.boost_gain};
      opbb_pkg::REG_CHCNT:  prdata = {28'd0, cfg_r.channel_count};
      opbb_pkg::REG_FORMAT: prdata = {31'd0, cfg_r.sample_format};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

// ----- src/opbb_ctrl.sv -----
// Sequencing state machine of the one-pole bass boost block.
module opbb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  opbb_pkg::dp_sts_t  sts,
  output opbb_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL_A = 3'd1;
  localparam logic [2:0] S_MUL_B = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_LOW   = 3'd4;
  localparam logic [2:0] S_MUL_C = 3'd5;
  localparam logic [2:0] S_ADD   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  // output register can take a new item this cycle
  assign out_free  = !out_valid_r || !out_stall;

  // next state and strobes
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.bypass ? S_OUT : S_MUL_A;
        end
      end
      S_MUL_A: begin
        cmd.mul_a = 1'b1;
        state_nxt = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_b = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_LOW;
      end
      S_LOW: begin
        cmd.low   = 1'b1;
        state_nxt = S_MUL_C;
      end
      S_MUL_C: begin
        cmd.mul_c = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/opbb_dp.sv -----
// Datapath of the one-pole bass boost block: channel store, shared multiplier,
// accumulator, rounding and saturation.
module opbb_dp #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  opbb_pkg::cfg_t     cfg,
  input  logic               clr,
  input  opbb_pkg::dp_cmd_t  cmd,
  output opbb_pkg::dp_sts_t  sts,
  input  logic [31:0]        sample_in,
  input  logic               first_of_block,
  output logic [31:0]        sample_out,
  output logic [2:0]         channel_out
);

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int AW   = opbb_pkg::ACC_W;
  localparam int CW   = opbb_pkg::CNT_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CHANNELS);

  // channel store with per-entry valid bits (invalid reads as zero)
  logic signed [31:0]      lp_mem_r [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] lp_vld_r;

  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      ch_r;
  logic signed [31:0] x_r;
  logic [31:0]        raw_r;
  logic               bypass_r;
  logic signed [AW-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic signed [31:0] low_r;
  logic [31:0]        sample_out_r;
  logic [2:0]         channel_out_r;

  logic [CW-1:0]      cnt_eff;
  logic [CW-1:0]      cc_ext;
  logic [CW-1:0]      ch_sel;
  logic [CW-1:0]      ch_inc;
  logic [CW-1:0]      idx_nxt;
  logic [CH_W-1:0]    ch_addr;
  logic signed [31:0] prev;
  logic signed [31:0] x_in;
  logic [16:0]        mul_a;
  logic signed [31:0] mul_b;
  logic signed [AW-1:0] mul_p;
  logic signed [AW-1:0] low_t;
  logic signed [31:0] low_v;
  logic signed [AW-1:0] x_sh;
  logic signed [AW-1:0] y_bias;
  logic signed [AW-1:0] y_t;
  logic signed [20:0] q16;
  logic signed [36:0] q32;
  logic [31:0]        y_sat;

  assign sts.bypass  = (cfg.boost_gain == 16'd0);
  assign sample_out  = sample_out_r;
  assign channel_out = channel_out_r;

  // effective channel count and rotation
  assign cc_ext = {{(CW-4){1'b0}}, cfg.channel_count};
  always_comb begin
    if (cc_ext == '0) begin
      cnt_eff = CW'(1);
    end else if (cc_ext > MAX_CNT) begin
      cnt_eff = MAX_CNT;
    end else begin
      cnt_eff = cc_ext;
    end
    ch_sel = first_of_block ? '0 : idx_r;
    if (ch_sel >= cnt_eff) begin
      ch_sel = '0;
    end
    ch_inc  = ch_sel + CW'(1);
    idx_nxt = (ch_inc >= cnt_eff) ? '0 : ch_inc;
  end

  assign ch_addr = ch_r[CH_W-1:0];
  assign prev    = lp_vld_r[ch_addr] ? lp_mem_r[ch_addr] : 32'sd0;

  // Q1.31 input: 16-bit samples sit in the top half
  assign x_in = (cfg.sample_format == opbb_pkg::FMT_S16) ?
                $signed({sample_in[15:0], 16'h0000}) : $signed(sample_in);

  // shared multiplier: 17-bit unsigned coefficient times 32-bit signed value
  always_comb begin
    if (cmd.mul_a) begin
      mul_a = {1'b0, cfg.alpha_coeff};
      mul_b = prev;
    end else if (cmd.mul_b) begin
      mul_a = 17'h1_0000 - {1'b0, cfg.alpha_coeff};
      mul_b = x_r;
    end else begin
      mul_a = {1'b0, cfg.boost_gain};
      mul_b = low_r;
    end
  end
  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  // low-pass divide by 2^16 toward zero
  assign low_t = acc_r + (acc_r[AW-1] ? AW'(16'hFFFF) : AW'(0));
  assign low_v = low_t[47:16];

  // x * 8192
  assign x_sh = {{(AW-32){x_r[31]}}, x_r} <<< 13;

  // output divide toward zero, then saturate to the sample width
  always_comb begin
    if (!acc_r[AW-1]) begin
      y_bias = '0;
    end else if (cfg.sample_format == opbb_pkg::FMT_S16) begin
      y_bias = AW'(29'h1FFF_FFFF);
    end else begin
      y_bias = AW'(13'h1FFF);
    end
    y_t = acc_r + y_bias;
    q16 = y_t[AW-1:29];
    q32 = y_t[AW-1:13];
    if (cfg.sample_format == opbb_pkg::FMT_S16) begin
      if (q16 > opbb_pkg::S16_MAX_Q) begin
        y_sat = opbb_pkg::S16_MAX_OUT;
      end else if (q16 < opbb_pkg::S16_MIN_Q) begin
        y_sat = opbb_pkg::S16_MIN_OUT;
      end else begin
        y_sat = {{16{q16[15]}}, q16[15:0]};
      end
    end else begin
      if (q32 > opbb_pkg::S32_MAX_Q) begin
        y_sat = opbb_pkg::S32_MAX_OUT;
      end else if (q32 < opbb_pkg::S32_MIN_Q) begin
        y_sat = opbb_pkg::S32_MIN_OUT;
      end else begin
        y_sat = q32[31:0];
      end
    end
  end

  // control-side state: rotation index and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      lp_vld_r <= '0;
    end else if (clr) begin
      idx_r    <= '0;
      lp_vld_r <= '0;
    end else begin
      if (cmd.load) begin
        idx_r <= idx_nxt;
      end
      if (cmd.low) begin
        lp_vld_r[ch_addr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r     <= ch_sel;
      x_r      <= x_in;
      raw_r    <= sample_in;
      bypass_r <= sts.bypass;
    end
    if (cmd.mul_a || cmd.mul_b || cmd.mul_c) begin
      prod_r <= mul_p;
    end
    if (cmd.mul_b) begin
      acc_r <= prod_r;
    end
    if (cmd.sum) begin
      acc_r <= acc_r + prod_r;
    end
    if (cmd.low) begin
      low_r             <= low_v;
      lp_mem_r[ch_addr] <= low_v;
    end
    if (cmd.add) begin
      acc_r <= x_sh + prod_r;
    end
    if (cmd.out_load) begin
      sample_out_r  <= bypass_r ? raw_r : y_sat;
      channel_out_r <= ch_r[2:0];
    end
  end

endmodule

// ----- src/one_pole_bass_boost_core.sv -----
// Top level of the one-pole bass boost block.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  in      | sink      | in_valid / in_stall | in_sample_in, in_first_of_block
//  out     | source    | out_valid/out_stall | out_sample_out, out_channel_out
//  config  | APB slave | psel/penable/pready | paddr, pwdata, prdata
//
// An item is accepted, then takes six steps through the single shared 18x32
// multiplier and accumulator, then is rounded and saturated into the output
// register. A zero boost gain skips the six steps and passes the raw sample on.
// Reset is synchronous; it clears the controller, the rotation index and the
// channel valid bits. The next item is taken while a result waits on a stalled
// output; the last step holds until the output register is free.
module one_pole_bass_boost_core #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_sample_in,
  input  logic        in_first_of_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_sample_out,
  output logic [2:0]  out_channel_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  opbb_pkg::cfg_t    cfg;
  opbb_pkg::dp_cmd_t cmd;
  opbb_pkg::dp_sts_t sts;
  logic              clr;

  opbb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .clr     (clr)
  );

  opbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  opbb_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .clr            (clr),
    .cmd            (cmd),
    .sts            (sts),
    .sample_in      (in_sample_in),
    .first_of_block (in_first_of_block),
    .sample_out     (out_sample_out),
    .channel_out    (out_channel_out)
  );

endmodule

// ----- src/opbb_chk.sv -----
// Port-level checks of the one-pole bass boost block, bound to the top level.
module opbb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_sample_out,
  input logic [2:0]  out_channel_out
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_sample_out) && $stable(out_channel_out))
    else $error("output payload changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again without a busy cycle");

  // a new result only comes out of a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

endmodule

bind one_pole_bass_boost_core opbb_chk u_chk (.*);

// ----- tb/one_pole_bass_boost_core_tb.sv -----
// Self-checking testbench for the one-pole bass boost core.
`timescale 1ns / 100ps

module one_pole_bass_boost_core_tb;

  localparam int MAX_CH         = 8;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int TAIL_CYCLES    = 24;
  localparam int MAX_REPORTS    = 40;

  // Expected result of one item
  typedef struct {
    logic [31:0] sample;
    logic [2:0]  chan;
  } boosted_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_sample_in;
  logic        in_first_of_block;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_sample_out;
  logic [2:0]  out_channel_out;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  one_pole_bass_boost_core #(
    .MAX_CHANNELS(MAX_CH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_in     (in_sample_in),
    .in_first_of_block(in_first_of_block),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_out   (out_sample_out),
    .out_channel_out  (out_channel_out),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of registers and per-channel filter state
  logic [15:0]        alpha_r;
  logic [15:0]        boost_r;
  logic [3:0]         chcnt_r;
  logic               fmt_r;
  logic signed [31:0] lp_state [MAX_CH];
  int unsigned        next_chan;

  boosted_t boosted_q[$];
  int       errors = 0;
  int       cycle_cnt = 0;

  // Sender burst control and receiver stall pattern
  int   burst_left = 0;
  int   gap_max = 0;
  int   stall_pct = 0;
  int   run_left = 0;
  logic stall_phase = 1'b0;
  logic holding = 1'b0;
  event holdoff_ev;

  function automatic int unsigned active_channels();
    if (chcnt_r == 4'd0) return 1;
    if (chcnt_r > MAX_CH) return MAX_CH;
    return chcnt_r;
  endfunction

  // Low-pass update and boost of one sample; advances the rotation
  function automatic boosted_t boost_predict(input logic [31:0] s, input logic first);
    longint      x;
    longint      acc;
    longint      low_v;
    longint      y;
    int unsigned cnt;
    int unsigned ch;
    boosted_t    r;
    cnt = active_channels();
    ch = first ? 0 : next_chan;
    if (ch >= cnt) ch = 0;
    next_chan = (ch + 1 >= cnt) ? 0 : ch + 1;
    r.chan = ch[2:0];
    // zero gain: raw pass-through, filter untouched
    if (boost_r == 16'd0) begin
      r.sample = s;
      return r;
    end
    if (fmt_r == opbb_pkg::FMT_S16) x = longint'(signed'(s[15:0])) * 65536;
    else x = longint'(signed'(s));
    acc = longint'(alpha_r) * longint'(lp_state[ch])
        + (longint'(65536) - longint'(alpha_r)) * x;
    low_v = acc / 65536;
    if (low_v > 64'sd2147483647) low_v = 64'sd2147483647;
    if (low_v < -64'sd2147483648) low_v = -64'sd2147483648;
    lp_state[ch] = low_v[31:0];
    acc = x * 8192 + longint'(boost_r) * longint'(lp_state[ch]);
    if (fmt_r == opbb_pkg::FMT_S16) begin
      y = acc / (longint'(1) <<< 29);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
    end else begin
      y = acc / 8192;
      if (y > 64'sd2147483647) y = 64'sd2147483647;
      if (y < -64'sd2147483648) y = -64'sd2147483648;
    end
    r.sample = y[31:0];
    return r;
  endfunction

  function automatic logic [31:0] reg_value(input logic [1:0] idx);
    case (idx)
      opbb_pkg::REG_ALPHA: return {16'd0, alpha_r};
      opbb_pkg::REG_BOOST: return {16'd0, boost_r};
      opbb_pkg::REG_CHCNT: return {28'd0, chcnt_r};
      default:             return {31'd0, fmt_r};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("ERROR @%0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("one_pole_bass_boost_core: mismatch");
      $finish;
    end
  end

  // Predict on every accepted input item
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      boosted_q.push_back(boost_predict(in_sample_in, in_first_of_block));
  end

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    boosted_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (boosted_q.size() == 0) begin
        report_mismatch("unexpected result", out_sample_out, 32'd0);
      end else begin
        want = boosted_q.pop_front();
        if (out_sample_out !== want.sample)
          report_mismatch("sample_out", out_sample_out, want.sample);
        if (out_channel_out !== want.chan)
          report_mismatch("channel_out", {29'd0, out_channel_out}, {29'd0, want.chan});
      end
    end
  end

  // Receiver: stall in runs of random length, or hold off completely
  always @(posedge clk) begin
    if (holding) begin
      out_stall <= 1'b1;
    end else if (stall_pct == 0) begin
      out_stall <= 1'b0;
    end else begin
      if (run_left == 0) begin
        stall_phase = ($urandom_range(0, 99) < stall_pct);
        run_left = stall_phase ? $urandom_range(1, 6) : $urandom_range(1, 10);
      end
      run_left--;
      out_stall <= stall_phase;
    end
  end

  // Long receiver hold-off, counted here
  initial forever begin
    @(holdoff_ev);
    holding = 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    holding = 1'b0;
  end

  // Offer one item, honoring burst gaps; returns once it is accepted
  task automatic send_item(input logic [31:0] s, input logic first);
    if (gap_max != 0 && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left != 0) burst_left--;
    in_valid          <= 1'b1;
    in_sample_in      <= s;
    in_first_of_block <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (boosted_q.size() != 0) @(posedge clk);
  endtask

  // Setup and access phases, then an idle phase before the next transfer
  task automatic apb_access(input logic [1:0] idx, input logic wr, input logic [31:0] val,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Register write while idle; mirrors it into the predictor
  task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] unused;
    drain();
    apb_access(idx, 1'b1, val, unused);
    case (idx)
      opbb_pkg::REG_ALPHA: alpha_r = val[15:0];
      opbb_pkg::REG_BOOST: boost_r = val[15:0];
      opbb_pkg::REG_CHCNT: begin
        chcnt_r = val[3:0];
        foreach (lp_state[i]) lp_state[i] = '0;
        next_chan = 0;
      end
      default: fmt_r = val[0];
    endcase
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [31:0] rd;
    apb_access(idx, 1'b0, 32'd0, rd);
    if (rd !== reg_value(idx)) report_mismatch("register readback", rd, reg_value(idx));
  endtask

  function automatic logic [31:0] pick_sample();
    logic [31:0] r;
    int          v;
    r = $urandom;
    v = $urandom_range(0, 2000) - 1000;
    case ($urandom_range(0, 9))
      0: r = (fmt_r == opbb_pkg::FMT_S32) ? 32'h7FFF_FFFF : {r[31:16], 16'h7FFF};
      1: r = (fmt_r == opbb_pkg::FMT_S32) ? 32'h8000_0000 : {r[31:16], 16'h8000};
      2: r = (fmt_r == opbb_pkg::FMT_S32) ? v : {r[31:16], v[15:0]};
      3: r = (fmt_r == opbb_pkg::FMT_S32) ? {{8{r[31]}}, r[23:0]}
                                          : {r[31:16], {4{r[15]}}, r[11:0]};
      default: ;
    endcase
    return r;
  endfunction

  // Reset values, 16-bit extremes, junk above bit 15 ignored
  task automatic test_reset_defaults();
    send_item(32'h0000_7FFF, 1'b1);
    send_item(32'h0000_8000, 1'b0);
    send_item(32'hABCD_7FFF, 1'b0);
    send_item(32'h0000_0000, 1'b1);
    send_item(32'hFFFF_8000, 1'b0);
    drain();
  endtask

  // Every register written with two values and read back
  task automatic test_registers();
    set_reg(opbb_pkg::REG_ALPHA, 32'd0);
    check_reg(opbb_pkg::REG_ALPHA);
    set_reg(opbb_pkg::REG_ALPHA, 32'd65535);
    check_reg(opbb_pkg::REG_ALPHA);
    set_reg(opbb_pkg::REG_BOOST, 32'd40960);
    check_reg(opbb_pkg::REG_BOOST);
    set_reg(opbb_pkg::REG_BOOST, 32'd65535);
    check_reg(opbb_pkg::REG_BOOST);
    set_reg(opbb_pkg::REG_CHCNT, 32'd8);
    check_reg(opbb_pkg::REG_CHCNT);
    set_reg(opbb_pkg::REG_CHCNT, 32'd1);
    check_reg(opbb_pkg::REG_CHCNT);
    set_reg(opbb_pkg::REG_FORMAT, {31'd0, opbb_pkg::FMT_S32});
    check_reg(opbb_pkg::REG_FORMAT);
    set_reg(opbb_pkg::REG_FORMAT, {31'd0, opbb_pkg::FMT_S16});
    check_reg(opbb_pkg::REG_FORMAT);
  endtask

  // 32-bit mode: saturation both ways with boost above range, alpha extremes
  task automatic test_format32();
    set_reg(opbb_pkg::REG_FORMAT, {31'd0, opbb_pkg::FMT_S32});
    set_reg(opbb_pkg::REG_CHCNT, 32'd2);
    set_reg(opbb_pkg::REG_ALPHA, 32'd0);
    set_reg(opbb_pkg::REG_BOOST, 32'd65535);
    send_item(32'h7FFF_FFFF, 1'b1);
    send_item(32'h8000_0000, 1'b0);
    set_reg(opbb_pkg::REG_ALPHA, 32'd65535);
    set_reg(opbb_pkg::REG_BOOST, 32'd40960);
    send_item(32'h7FFF_FFFF, 1'b1);
    send_item(32'h1234_5678, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    drain();
  endtask

  // Zero gain: samples pass unchanged in both formats, rotation still runs
  task automatic test_bypass();
    set_reg(opbb_pkg::REG_BOOST, 32'd0);
    set_reg(opbb_pkg::REG_FORMAT, {31'd0, opbb_pkg::FMT_S16});
    send_item(32'hDEAD_8001, 1'b1);
    send_item($urandom, 1'b0);
    set_reg(opbb_pkg::REG_FORMAT, {31'd0, opbb_pkg::FMT_S32});
    send_item(32'h8000_0000, 1'b0);
    drain();
  endtask

  // Channel count of zero acts as one, above the maximum acts as the maximum
  task automatic test_channel_count();
    set_reg(opbb_pkg::REG_BOOST, 32'd8192);
    set_reg(opbb_pkg::REG_ALPHA, 32'd32768);
    set_reg(opbb_pkg::REG_CHCNT, 32'd0);
    send_item(32'h4000_0000, 1'b0);
    send_item(32'hC000_0000, 1'b0);
    set_reg(opbb_pkg::REG_CHCNT, 32'd12);
    for (int k = 0; k < 9; k++) send_item($urandom, 1'b0);
    drain();
  endtask

  // Receiver holds off while the sender keeps offering; then random stalls and gaps
  task automatic test_backpressure();
    set_reg(opbb_pkg::REG_CHCNT, 32'd4);
    set_reg(opbb_pkg::REG_ALPHA, 32'd63843);
    gap_max = 0;
    stall_pct = 0;
    -> holdoff_ev;
    for (int k = 0; k < 30; k++) send_item(pick_sample(), (k % 4) == 0);
    drain();
    stall_pct = 50;
    gap_max = 3;
    for (int k = 0; k < 20; k++) send_item(pick_sample(), (k % 4) == 0);
    drain();
  endtask

  // One random configuration, then mostly well-formed blocks of frames
  task automatic random_phase(input int n_items);
    int       sent;
    int       cnt;
    int       blk_len;
    int       v;
    sent = 0;
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = 65535;
      2: v = 63843 - $urandom_range(0, 3000);
      default: v = $urandom_range(0, 65535);
    endcase
    set_reg(opbb_pkg::REG_ALPHA, v);
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 40960;
      2: v = 65535;
      3: v = 8192;
      default: v = $urandom_range(1, 40960);
    endcase
    set_reg(opbb_pkg::REG_BOOST, v);
    if ($urandom_range(0, 1) == 0) begin
      v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, MAX_CH);
      set_reg(opbb_pkg::REG_CHCNT, v);
    end
    set_reg(opbb_pkg::REG_FORMAT, $urandom_range(0, 1));
    cnt = active_channels();
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: random block marker
        send_item(pick_sample(), $urandom_range(0, 1));
        sent++;
      end else begin
        blk_len = cnt * $urandom_range(1, 6);
        // occasionally a broken block with a partial frame
        if ($urandom_range(0, 7) == 0) blk_len = blk_len + $urandom_range(1, cnt);
        for (int k = 0; k < blk_len && sent < n_items; k++) begin
          send_item(pick_sample(), k == 0);
          sent++;
        end
      end
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 10; p++) begin
      drain();
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 20;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 25;
        default: stall_pct = 60;
      endcase
      if (p == 0) begin
        gap_max = 0;
        stall_pct = 0;
      end
      random_phase(95);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_sample_in      = '0;
    in_first_of_block = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    alpha_r           = opbb_pkg::ALPHA_RST;
    boost_r           = opbb_pkg::BOOST_RST;
    chcnt_r           = opbb_pkg::CHCNT_RST;
    fmt_r             = opbb_pkg::FORMAT_RST;
    foreach (lp_state[i]) lp_state[i] = '0;
    next_chan         = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_registers();
    test_format32();
    test_bypass();
    test_channel_count();
    test_backpressure();
    test_random();

    // all results in; leave room for anything extra to show up
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("one_pole_bass_boost_core: match");
    end else begin
      $display("one_pole_bass_boost_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/opbb_pkg.sv
src/opbb_cfg.sv
src/opbb_ctrl.sv
src/opbb_dp.sv
src/one_pole_bass_boost_core.sv
src/opbb_chk.sv
tb/one_pole_bass_boost_core_tb.sv
